### src/assert_macros.svh
// Assertion macros used by the checker file of the meter block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define PMB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define PMB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/pmb_pkg.sv
// Package with the types, constants and helper functions of the meter block.
package pmb_pkg;

   // Channel count limits.
   localparam int MAX_CHANNELS     = 8;
   localparam int CHANNELS_DEFAULT = 8;

   // Field widths.
   localparam int TIME_W  = 32;
   localparam int RAW_W   = 32;
   localparam int PCT_W   = 7;
   localparam int LEVEL_W = 17;
   localparam int CSR_W   = 10;
   localparam int DROP_W  = 2 * CSR_W;

   // Scale and ballistics constants.
   localparam logic signed [RAW_W-1:0] LEVEL_FLOOR   = 32'sd9600;
   localparam logic [PCT_W-1:0]        PCT_FULL      = 7'd100;
   localparam logic [LEVEL_W-1:0]      MILLI_PER_PCT = 17'd1000;
   localparam logic [CSR_W-1:0]        DECAY_CAP_MS  = 10'd1000;
   localparam logic [CSR_W-1:0]        HOLD_MS_RESET = 10'd80;
   localparam logic [CSR_W-1:0]        DECAY_RESET   = 10'd120;

   // Reciprocal constants: x/3 as (x*171)>>9, x/125 as (x*8389)>>20.
   localparam logic [15:0] RECIP_3   = 16'd171;
   localparam logic [27:0] RECIP_125 = 28'd8389;

   // Register indexes of the configuration port.
   typedef enum logic [0:0] {
      REG_HOLD_MS      = 1'b0,
      REG_DECAY_PER_MS = 1'b1
   } csr_index_type;

   typedef logic [PCT_W-1:0]   pct_type;
   typedef logic [LEVEL_W-1:0] level_type;

   // Control group handed from the top level to every channel.
   typedef struct packed {
      logic              update;
      logic              history_valid;
      logic [CSR_W-1:0]  hold_ms;
      logic [CSR_W-1:0]  decay_per_ms;
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] elapsed_ms;
   } ctrl_type;

   // Held level in thousandths of a percent to whole percent (level <= 100000).
   function automatic pct_type level_to_pct(input level_type level);
      logic [27:0] prod;
      prod = {14'd0, level[LEVEL_W-1:3]} * RECIP_125;
      return prod[26:20];
   endfunction

endpackage

### src/pmb_level_map.sv
// Maps one signed meter reading to a display percentage of 0 to 100.
module pmb_level_map (
   input  logic signed [pmb_pkg::RAW_W-1:0] raw_level,
   output pmb_pkg::pct_type                 pct
);
   import pmb_pkg::*;

   logic signed [RAW_W-1:0] offset;
   logic [8:0]              scaled;
   logic [15:0]             prod;

   // The offset lies in 1..9599 inside the sloped range; divide by 32, then by 3.
   assign offset = raw_level + LEVEL_FLOOR;
   assign scaled = offset[13:5];
   assign prod   = {7'd0, scaled} * RECIP_3;

   always_comb begin
      if (raw_level <= -LEVEL_FLOOR) begin
         pct = '0;
      end else if (raw_level >= 0) begin
         pct = PCT_FULL;
      end else begin
         pct = prod[15:9];
      end
   end

endmodule

### src/pmb_channel.sv
// Hold and decay state of one meter channel with its update logic.
module pmb_channel (
   input  logic               clock,
   input  logic               reset,
   input  pmb_pkg::ctrl_type  ctrl,
   input  pmb_pkg::pct_type   target_pct,
   output pmb_pkg::level_type level_next
);
   import pmb_pkg::*;

   level_type         held_level_ff, held_level_in;
   logic [TIME_W-1:0] peak_time_ff, peak_time_in;
   level_type         target;
   logic [TIME_W-1:0] age;
   logic [TIME_W-1:0] over_hold;
   logic [TIME_W-1:0] capped_elapsed;
   logic [CSR_W-1:0]  fall_ms;
   logic [DROP_W-1:0] drop;
   level_type         gap;
   level_type         take;
   logic              jump;

   assign target = {10'd0, target_pct} * MILLI_PER_PCT;
   assign jump   = !ctrl.history_valid || (target >= held_level_ff);

   // Milliseconds past the hold time, capped by the update gap and one second.
   assign age       = ctrl.now_ms - peak_time_ff;
   assign over_hold = (age > TIME_W'(ctrl.hold_ms)) ? age - TIME_W'(ctrl.hold_ms) : '0;
   assign capped_elapsed = (over_hold > ctrl.elapsed_ms) ? ctrl.elapsed_ms : over_hold;
   assign fall_ms = (capped_elapsed > TIME_W'(DECAY_CAP_MS)) ? DECAY_CAP_MS
                                                             : capped_elapsed[CSR_W-1:0];

   // The drop never takes the level below the target.
   assign drop = DROP_W'(fall_ms) * DROP_W'(ctrl.decay_per_ms);
   assign gap  = held_level_ff - target;
   assign take = (drop < DROP_W'(gap)) ? drop[LEVEL_W-1:0] : gap;

   always_comb begin
      if (jump) begin
         level_next   = target;
         peak_time_in = ctrl.now_ms;
      end else begin
         level_next   = held_level_ff - take;
         peak_time_in = peak_time_ff;
      end
      held_level_in = level_next;
   end

   // State moves only on an accepted valid reading.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_level_ff <= '0;
         peak_time_ff  <= '0;
      end else if (ctrl.update) begin
         held_level_ff <= held_level_in;
         peak_time_ff  <= peak_time_in;
      end
   end

endmodule

### src/peak_meter_ballistics.sv
// Top level of the eight-channel peak meter ballistics block.
//
//   channel   direction  ports                              moves
//   req       in         req_valid/req_ready                timestamp, flag, 8 readings
//   rsp       out        rsp_valid/rsp_ready                8 shown levels
//   csr       in         csr_write_enable (no handshake)    hold_ms, decay_per_ms
//
// A request is registered on acceptance (its readings already mapped to
// percent), then the per-channel logic updates the channel state and loads
// the result register; one request per cycle unless a stalled response holds it up.
// A request with the readings flag low only clears the history and gives no
// response. A stalled response holds the result register; one request can
// wait behind it in the input register. Reset is synchronous.
module peak_meter_ballistics #(
   parameter int CHANNELS = pmb_pkg::CHANNELS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [pmb_pkg::TIME_W-1:0]       req_now_ms,
   input  logic                             req_reading_valid,
   input  logic signed [pmb_pkg::RAW_W-1:0] req_raw_level_0,
   input  logic signed [pmb_pkg::RAW_W-1:0] req_raw_level_1,
   input  logic signed [pmb_pkg::RAW_W-1:0] req_raw_level_2,
   input  logic signed [pmb_pkg::RAW_W-1:0] req_raw_level_3,
   input  logic signed [pmb_pkg::RAW_W-1:0] req_raw_level_4,
   input  logic signed [pmb_pkg::RAW_W-1:0] req_raw_level_5,
   input  logic signed [pmb_pkg::RAW_W-1:0] req_raw_level_6,
   input  logic signed [pmb_pkg::RAW_W-1:0] req_raw_level_7,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output pmb_pkg::pct_type                 rsp_shown_level_0,
   output pmb_pkg::pct_type                 rsp_shown_level_1,
   output pmb_pkg::pct_type                 rsp_shown_level_2,
   output pmb_pkg::pct_type                 rsp_shown_level_3,
   output pmb_pkg::pct_type                 rsp_shown_level_4,
   output pmb_pkg::pct_type                 rsp_shown_level_5,
   output pmb_pkg::pct_type                 rsp_shown_level_6,
   output pmb_pkg::pct_type                 rsp_shown_level_7,
   input  logic                             csr_write_enable,
   input  pmb_pkg::csr_index_type           csr_index,
   input  logic [pmb_pkg::CSR_W-1:0]        csr_write_data
);
   import pmb_pkg::*;

   logic signed [RAW_W-1:0] raw_level [MAX_CHANNELS];
   pct_type                 raw_pct   [MAX_CHANNELS];
   pct_type                 shown     [MAX_CHANNELS];
   level_type               level_next[MAX_CHANNELS];

   logic              in_valid_ff, in_valid_in;
   logic              in_reading_ff;
   logic [TIME_W-1:0] in_now_ff;
   pct_type           in_pct_ff [MAX_CHANNELS];
   logic              rsp_valid_ff, rsp_valid_in;
   level_type         rsp_level_ff [MAX_CHANNELS];
   logic [TIME_W-1:0] last_update_ff, last_update_in;
   logic              history_ff, history_in;
   logic [CSR_W-1:0]  hold_ms_ff, hold_ms_in;
   logic [CSR_W-1:0]  decay_ff, decay_in;
   logic              accept;
   logic              advance;
   logic              update;
   ctrl_type          ctrl;

   assign raw_level[0] = req_raw_level_0;
   assign raw_level[1] = req_raw_level_1;
   assign raw_level[2] = req_raw_level_2;
   assign raw_level[3] = req_raw_level_3;
   assign raw_level[4] = req_raw_level_4;
   assign raw_level[5] = req_raw_level_5;
   assign raw_level[6] = req_raw_level_6;
   assign raw_level[7] = req_raw_level_7;

   // Handshake: the input register empties whenever its request can move on.
   assign advance   = in_valid_ff && (!in_reading_ff || !rsp_valid_ff || rsp_ready);
   assign update    = advance && in_reading_ff;
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = update || (rsp_valid_ff && !rsp_ready);

   // Shared history state.
   always_comb begin
      last_update_in = last_update_ff;
      history_in     = history_ff;
      if (advance) begin
         history_in = in_reading_ff;
         if (in_reading_ff) begin
            last_update_in = in_now_ff;
         end
      end
   end

   // Configuration writes.
   always_comb begin
      hold_ms_in = hold_ms_ff;
      decay_in   = decay_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_HOLD_MS: begin
               hold_ms_in = csr_write_data;
            end
            REG_DECAY_PER_MS: begin
               decay_in = csr_write_data;
            end
            default: begin
               hold_ms_in = hold_ms_ff;
            end
         endcase
      end
   end

   assign ctrl.update        = update;
   assign ctrl.history_valid = history_ff;
   assign ctrl.hold_ms       = hold_ms_ff;
   assign ctrl.decay_per_ms  = decay_ff;
   assign ctrl.now_ms        = in_now_ff;
   assign ctrl.elapsed_ms    = in_now_ff - last_update_ff;

   // Per-channel mapping, state and output scaling.
   for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_chan
      pmb_level_map u_map (
         .raw_level (raw_level[i]),
         .pct       (raw_pct[i])
      );

      if (i < CHANNELS) begin : g_used
         pmb_channel u_channel (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .target_pct (in_pct_ff[i]),
            .level_next (level_next[i])
         );
      end else begin : g_unused
         assign level_next[i] = '0;
      end

      assign shown[i] = level_to_pct(rsp_level_ff[i]);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         history_ff     <= 1'b0;
         last_update_ff <= '0;
         hold_ms_ff     <= HOLD_MS_RESET;
         decay_ff       <= DECAY_RESET;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         history_ff     <= history_in;
         last_update_ff <= last_update_in;
         hold_ms_ff     <= hold_ms_in;
         decay_ff       <= decay_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_reading_ff <= req_reading_valid;
         in_now_ff     <= req_now_ms;
         in_pct_ff     <= raw_pct;
      end
      if (update) begin
         rsp_level_ff <= level_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_shown_level_0 = shown[0];
   assign rsp_shown_level_1 = shown[1];
   assign rsp_shown_level_2 = shown[2];
   assign rsp_shown_level_3 = shown[3];
   assign rsp_shown_level_4 = shown[4];
   assign rsp_shown_level_5 = shown[5];
   assign rsp_shown_level_6 = shown[6];
   assign rsp_shown_level_7 = shown[7];

endmodule

### src/pmb_checker.sv
// Port-level checker for the meter block and its bind to the top level.
`include "assert_macros.svh"

module pmb_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pmb_pkg::pct_type rsp_shown_level_0,
   input pmb_pkg::pct_type rsp_shown_level_1,
   input pmb_pkg::pct_type rsp_shown_level_2,
   input pmb_pkg::pct_type rsp_shown_level_3,
   input pmb_pkg::pct_type rsp_shown_level_4,
   input pmb_pkg::pct_type rsp_shown_level_5,
   input pmb_pkg::pct_type rsp_shown_level_6,
   input pmb_pkg::pct_type rsp_shown_level_7
);
   import pmb_pkg::*;

   logic in_range;
   logic [8*PCT_W-1:0] levels;

   assign levels = {rsp_shown_level_7, rsp_shown_level_6, rsp_shown_level_5,
                    rsp_shown_level_4, rsp_shown_level_3, rsp_shown_level_2,
                    rsp_shown_level_1, rsp_shown_level_0};

   assign in_range = (rsp_shown_level_0 <= PCT_FULL) && (rsp_shown_level_1 <= PCT_FULL) &&
                     (rsp_shown_level_2 <= PCT_FULL) && (rsp_shown_level_3 <= PCT_FULL) &&
                     (rsp_shown_level_4 <= PCT_FULL) && (rsp_shown_level_5 <= PCT_FULL) &&
                     (rsp_shown_level_6 <= PCT_FULL) && (rsp_shown_level_7 <= PCT_FULL);

   // Every shown level stays within the percent scale.
   `PMB_ASSERT(a_level_range, clock, reset, rsp_valid |-> in_range, "shown level above 100")

   // With no response pending the block always takes a request.
   `PMB_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "request refused while idle")

   // A stalled response holds its levels.
   `PMB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(levels), "stalled response changed")

   // A request that is not yet taken stays offered.
   `PMB_ASSERT(a_req_hold, clock, reset, req_valid && !req_ready |=> req_valid, "request withdrawn")

   // Reset leaves no response behind.
   `PMB_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind peak_meter_ballistics pmb_checker u_pmb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_shown_level_0 (rsp_shown_level_0),
   .rsp_shown_level_1 (rsp_shown_level_1),
   .rsp_shown_level_2 (rsp_shown_level_2),
   .rsp_shown_level_3 (rsp_shown_level_3),
   .rsp_shown_level_4 (rsp_shown_level_4),
   .rsp_shown_level_5 (rsp_shown_level_5),
   .rsp_shown_level_6 (rsp_shown_level_6),
   .rsp_shown_level_7 (rsp_shown_level_7)
);
